// ----- design/multi_cpu_thread_dispatcher_assert.svh -----
// Assertion macros for the thread dispatcher controller.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MULTI_CPU_THREAD_DISPATCHER_ASSERT_SVH
`define MULTI_CPU_THREAD_DISPATCHER_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define MCTD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check an implication whose consequent must hold in the next cycle.
`define MCTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mctd_pkg.sv -----
// Package for the thread dispatcher: sizes, payload structs, command codes.
// Depends on nothing.
package mctd_pkg;

   localparam int MAX_THREADS_DEF = 32;
   localparam int MAX_CPUS_DEF    = 16;

   localparam logic [1:0] POL_FCFS     = 2'd0;
   localparam logic [1:0] POL_SRT_NP   = 2'd1;
   localparam logic [1:0] POL_SRT_P    = 2'd2;
   localparam logic [1:0] POL_PRIO_P   = 2'd3;

   localparam logic       OP_CREATE = 1'b0;
   localparam logic       OP_TICK   = 1'b1;

   localparam logic       CSR_POLICY = 1'b0;
   localparam logic       CSR_CPUS   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] arrive_at;
      logic [15:0] run_time;
      logic [7:0]  prio_level;
      logic [15:0] new_thread_id;
      logic [15:0] current_time;
   } req_type;

   typedef struct packed {
      logic [3:0]  cpu_index;
      logic [15:0] assigned_id;
      logic        cpu_busy;
      logic        all_done;
      logic        table_full;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;    // capture the input item
      logic create;      // write the new thread into the free slot
      logic drop;        // drop finished threads, release owners
      logic scan_clear;  // start a scan for one CPU
      logic scan_step;   // compare one slot
      logic assign_cpu;  // commit the scan winner to the current CPU
      logic next_cpu;    // advance the CPU counter
      logic run;         // decrement every running thread
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic any_valid;
      logic scan_last;
      logic cpu_last;
      logic cpu_idle;
   } stat_type;

endpackage

// ----- design/mctd_datapath.sv -----
// Datapath of the thread dispatcher: thread table, CPU map, scan comparator.
// Depends on mctd_pkg.
module mctd_datapath
   import mctd_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int MAX_CPUS    = MAX_CPUS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic [1:0] policy_ff,
   input  logic [4:0] cpus_ff,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  result
);
   localparam int SW = $clog2(MAX_THREADS);
   localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

   // Thread table held in flip-flops, read one slot per scan step.
   logic [MAX_THREADS-1:0] valid_ff, valid_in;
   logic [MAX_THREADS-1:0] owned_ff, owned_in;
   logic [15:0] arr_ff [MAX_THREADS];
   logic [15:0] rem_ff [MAX_THREADS];
   logic [7:0]  pri_ff [MAX_THREADS];
   logic [15:0] id_ff  [MAX_THREADS];
   logic [CW-1:0] own_ff [MAX_THREADS];
   logic [15:0] ord_ff [MAX_THREADS];
   logic [15:0] insert_ff;
   logic [MAX_CPUS-1:0] cbusy_ff, cbusy_in;
   logic [SW-1:0] cslot_ff [MAX_CPUS];

   req_type req_ff;
   logic [SW-1:0] scan_ff;
   logic [CW-1:0] cpu_ff;
   logic [SW-1:0] best_ff;
   logic          found_ff;
   logic [4:0]    count;
   logic [SW-1:0] free_slot;
   logic          free_ok;
   logic          cand_ok, ahead;
   logic [15:0]   ka, kb;

   // Effective CPU count, saturated to the legal range.
   always_comb begin
      if (cpus_ff == 5'd0) count = 5'd1;
      else if (32'(cpus_ff) > MAX_CPUS) count = 5'(MAX_CPUS);
      else count = cpus_ff;
   end

   // Lowest free slot.
   always_comb begin
      free_slot = '0;
      free_ok   = 1'b0;
      for (int s = MAX_THREADS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_slot = SW'(s);
            free_ok   = 1'b1;
         end
      end
   end

   // Rank compare of the scanned slot against the current best.
   always_comb begin
      cand_ok = valid_ff[scan_ff] && !owned_ff[scan_ff]
                && (arr_ff[scan_ff] <= req_ff.current_time);
      unique case (policy_ff)
         POL_SRT_NP, POL_SRT_P: begin
            ka = rem_ff[scan_ff];
            kb = rem_ff[best_ff];
         end
         POL_PRIO_P: begin
            ka = {8'd0, pri_ff[scan_ff]};
            kb = {8'd0, pri_ff[best_ff]};
         end
         default: begin
            ka = '0;
            kb = '0;
         end
      endcase
      if (ka != kb) ahead = ka < kb;
      else if (arr_ff[scan_ff] != arr_ff[best_ff]) ahead = arr_ff[scan_ff] < arr_ff[best_ff];
      else ahead = ord_ff[scan_ff] < ord_ff[best_ff];
   end

   assign stat.is_tick   = req_ff.operation == OP_TICK;
   assign stat.any_valid = |valid_ff;
   assign stat.scan_last = 32'(scan_ff) == MAX_THREADS - 1;
   assign stat.cpu_last  = 5'(cpu_ff) + 5'd1 == count;
   assign stat.cpu_idle  = !cbusy_ff[cpu_ff];

   // Result word for the current step.
   always_comb begin
      result = '0;
      if (!stat.is_tick) begin
         result.table_full = !free_ok;
         result.last       = 1'b1;
      end else if (!stat.any_valid) begin
         result.all_done = 1'b1;
         result.last     = 1'b1;
      end else begin
         result.cpu_index = 4'(cpu_ff);
         if (cbusy_ff[cpu_ff] || found_ff) begin
            result.cpu_busy    = 1'b1;
            result.assigned_id = cbusy_ff[cpu_ff] ? id_ff[cslot_ff[cpu_ff]] : id_ff[best_ff];
         end
         result.last = stat.cpu_last;
      end
   end

   // Next values of the valid, owned and CPU busy bits.
   always_comb begin
      valid_in = valid_ff;
      owned_in = owned_ff;
      cbusy_in = cbusy_ff;
      if (cmd.create && free_ok) valid_in[free_slot] = 1'b1;
      if (cmd.create && free_ok) owned_in[free_slot] = 1'b0;
      if (cmd.drop) begin
         for (int s = 0; s < MAX_THREADS; s++) begin
            if (valid_ff[s] && rem_ff[s] == 16'd0) begin
               valid_in[s] = 1'b0;
               owned_in[s] = 1'b0;
            end
            if (owned_ff[s] && (policy_ff[1] || 5'(own_ff[s]) >= count))
               owned_in[s] = 1'b0;
         end
         for (int c = 0; c < MAX_CPUS; c++) begin
            if (!valid_in[cslot_ff[c]] || policy_ff[1] || c >= 32'(count))
               cbusy_in[c] = 1'b0;
         end
      end
      if (cmd.assign_cpu && !cbusy_ff[cpu_ff] && found_ff) begin
         cbusy_in[cpu_ff] = 1'b1;
         owned_in[best_ff] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         owned_ff  <= '0;
         cbusy_ff  <= '0;
         insert_ff <= '0;
         scan_ff   <= '0;
         cpu_ff    <= '0;
         found_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         owned_ff <= owned_in;
         cbusy_ff <= cbusy_in;
         if (cmd.create && free_ok) insert_ff <= insert_ff + 16'd1;
         if (cmd.load_req) cpu_ff <= '0;
         else if (cmd.next_cpu) cpu_ff <= cpu_ff + CW'(1);
         if (cmd.scan_clear) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            scan_ff <= scan_ff + SW'(1);
            if (cand_ok && (!found_ff || ahead)) found_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      if (cmd.scan_step && cand_ok && (!found_ff || ahead)) best_ff <= scan_ff;
      if (cmd.create && free_ok) begin
         arr_ff[free_slot] <= req_ff.arrive_at;
         rem_ff[free_slot] <= req_ff.run_time;
         pri_ff[free_slot] <= req_ff.prio_level;
         id_ff[free_slot]  <= req_ff.new_thread_id;
         ord_ff[free_slot] <= insert_ff;
      end
      if (cmd.assign_cpu && !cbusy_ff[cpu_ff] && found_ff) begin
         cslot_ff[cpu_ff] <= best_ff;
         own_ff[best_ff]  <= cpu_ff;
      end
      if (cmd.run) begin
         for (int c = 0; c < MAX_CPUS; c++) begin
            if (cbusy_ff[c] && rem_ff[cslot_ff[c]] != 16'd0)
               rem_ff[cslot_ff[c]] <= rem_ff[cslot_ff[c]] - 16'd1;
         end
      end
   end

endmodule

// ----- design/mctd_control.sv -----
// Controller state machine of the thread dispatcher.
// Depends on mctd_pkg and the assertion macro header.
`include "multi_cpu_thread_dispatcher_assert.svh"
module mctd_control
   import mctd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_ONE = 3'd4;
   localparam logic [2:0] ST_RUN = 3'd5;
   localparam logic [2:0] ST_DROP = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_EMIT || state_ff == ST_ONE;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_tick) begin
               cmd.drop = 1'b1;
               state_in = ST_DROP;
            end else begin
               state_in = ST_ONE;
            end
         end
         ST_DROP: begin
            cmd.scan_clear = 1'b1;
            state_in = stat.any_valid ? ST_SCAN : ST_ONE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last || !stat.cpu_idle) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.assign_cpu = 1'b1;
               cmd.scan_clear = 1'b1;
               if (stat.cpu_last) begin
                  state_in = ST_RUN;
               end else begin
                  cmd.next_cpu = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ONE: begin
            if (!rsp_stall) begin
               cmd.create = !stat.is_tick;
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   `MCTD_ASSERT_IMPL(a_stall_busy, clock, reset, state_ff != ST_IDLE, req_stall, "not stalled while busy")
   `MCTD_ASSERT_NEXT(a_run_idle, clock, reset, state_ff == ST_RUN, state_ff == ST_IDLE, "run not followed by idle")
   `MCTD_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.create, cmd.drop, cmd.run, cmd.scan_step}), "conflicting commands")

endmodule

// ----- design/multi_cpu_thread_dispatcher.sv -----
// Multiprocessor thread dispatcher: FCFS, shortest remaining, priority.
// Usage:
//   req_ channel carries a create or a tick item (valid/stall handshake).
//   rsp_ channel returns results; rsp_data.last marks an item's final one.
//   csr_ port writes policy_mode (index 0) and cpus_in_use (index 1).
// A create gives one result from the single-result state after decoding, and
// the block returns to idle before the next item can be accepted.
// A tick drops finished threads, then for each CPU in use scans the
// thread table one slot a cycle (the whole table for an idle CPU, ending
// early for a CPU that keeps its thread) and emits that CPU's assignment.
// The scan runs through the single shared slot comparator; one item is in
// work at a time. An empty table gives a single all_done result instead.
// The input is stalled from acceptance until the item has finished.
// When the receiver stalls rsp_, the block holds the result and waits.
// Synchronous reset empties the table, idles every CPU, sets FCFS and
// one CPU in use.
module multi_cpu_thread_dispatcher
   import mctd_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int MAX_CPUS    = MAX_CPUS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [4:0] csr_data
);
   logic [1:0] policy_ff;
   logic [4:0] cpus_ff;
   cmd_type    cmd;
   stat_type   stat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FCFS;
         cpus_ff   <= 5'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POLICY: policy_ff <= csr_data[1:0];
            CSR_CPUS:   cpus_ff   <= csr_data;
            default:    ;
         endcase
      end
   end

   mctd_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   mctd_datapath #(.MAX_THREADS(MAX_THREADS), .MAX_CPUS(MAX_CPUS)) u_datapath (
      .clock, .reset, .policy_ff, .cpus_ff, .req_data, .cmd, .stat,
      .result(rsp_data)
   );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the multi-CPU thread dispatcher.
// Depends on mctd_pkg and the multi_cpu_thread_dispatcher RTL only.
`timescale 1ns / 100ps

module tb_top;
   import mctd_pkg::*;

   localparam int NT = MAX_THREADS_DEF;
   localparam int NC = MAX_CPUS_DEF;
   localparam int NO_CPU = NC;
   localparam int NO_SLOT = NT;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 700;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic       csr_index = CSR_POLICY;
   logic [4:0] csr_data = '0;

   multi_cpu_thread_dispatcher uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predicted scheduler state.
   bit          thr_valid [NT];
   bit [15:0]   thr_arrival [NT];
   bit [15:0]   thr_remaining [NT];
   bit [7:0]    thr_prio [NT];
   bit [15:0]   thr_id [NT];
   bit [15:0]   thr_order [NT];
   int          thr_owner [NT];
   int          cpu_thread [NC];
   bit [15:0]   insert_count;
   logic [1:0]  policy;
   logic [4:0]  cpu_count;

   rsp_type     pending_assign [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          checked_count = 0;
   int          tick_count = 0;
   int          create_count = 0;
   int          full_count = 0;
   bit          idle_on = 1'b1;
   int          stall_left = 0;
   bit [15:0]   now_time = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_assign.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Receiver backpressure in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input int exp_v, input int got_v);
      error_count++;
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, exp_v,
               got_v);
   endtask

   // Compare each result transfer with the oldest predicted assignment.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_assign.size() == 0) begin
            report_mismatch("unexpected result, cpu_index", -1, int'(rsp_data.cpu_index));
         end else begin
            e = pending_assign.pop_front();
            checked_count++;
            if (rsp_data.cpu_index !== e.cpu_index)
               report_mismatch("cpu_index", int'(e.cpu_index), int'(rsp_data.cpu_index));
            if (rsp_data.assigned_id !== e.assigned_id)
               report_mismatch("assigned_id", int'(e.assigned_id),
                               int'(rsp_data.assigned_id));
            if (rsp_data.cpu_busy !== e.cpu_busy)
               report_mismatch("cpu_busy", int'(e.cpu_busy), int'(rsp_data.cpu_busy));
            if (rsp_data.all_done !== e.all_done)
               report_mismatch("all_done", int'(e.all_done), int'(rsp_data.all_done));
            if (rsp_data.table_full !== e.table_full)
               report_mismatch("table_full", int'(e.table_full), int'(rsp_data.table_full));
            if (rsp_data.last !== e.last)
               report_mismatch("last", int'(e.last), int'(rsp_data.last));
         end
      end
   end

   // True when thread a is served ahead of thread b under the current policy.
   function automatic bit ranks_first(input int a, input int b);
      bit [15:0] ka;
      bit [15:0] kb;
      ka = 0;
      kb = 0;
      if (policy == POL_SRT_NP || policy == POL_SRT_P) begin
         ka = thr_remaining[a];
         kb = thr_remaining[b];
      end else if (policy == POL_PRIO_P) begin
         ka = {8'd0, thr_prio[a]};
         kb = {8'd0, thr_prio[b]};
      end
      if (ka != kb) return ka < kb;
      if (thr_arrival[a] != thr_arrival[b]) return thr_arrival[a] < thr_arrival[b];
      return thr_order[a] < thr_order[b];
   endfunction

   function automatic int pick_thread(input bit [15:0] now);
      int best;
      best = NO_SLOT;
      for (int s = 0; s < NT; s++) begin
         if (thr_valid[s] && thr_owner[s] == NO_CPU && thr_arrival[s] <= now)
            if (best == NO_SLOT || ranks_first(s, best)) best = s;
      end
      return best;
   endfunction

   function automatic bit table_empty();
      foreach (thr_valid[s]) if (thr_valid[s]) return 1'b0;
      return 1'b1;
   endfunction

   // Update the predicted state for one accepted item and queue its results.
   function automatic void predict_dispatch(input req_type r);
      rsp_type e;
      int cnt;
      int b;
      bit any;
      e = '0;
      e.last = 1'b1;
      if (r.operation == OP_CREATE) begin
         create_count++;
         e.table_full = 1'b1;
         for (int s = 0; s < NT; s++) begin
            if (!thr_valid[s]) begin
               thr_valid[s] = 1'b1;
               thr_arrival[s] = r.arrive_at;
               thr_remaining[s] = r.run_time;
               thr_prio[s] = r.prio_level;
               thr_id[s] = r.new_thread_id;
               thr_owner[s] = NO_CPU;
               thr_order[s] = insert_count;
               insert_count++;
               e.table_full = 1'b0;
               break;
            end
         end
         if (e.table_full) full_count++;
         pending_assign = {pending_assign, e};
         return;
      end
      tick_count++;
      cnt = int'(cpu_count);
      if (cnt < 1) cnt = 1;
      if (cnt > NC) cnt = NC;
      any = 1'b0;
      for (int s = 0; s < NT; s++) begin
         if (thr_valid[s] && thr_remaining[s] == 0) begin
            thr_valid[s] = 1'b0;
            thr_owner[s] = NO_CPU;
         end
         if (thr_valid[s]) any = 1'b1;
      end
      for (int c = 0; c < NC; c++)
         if (cpu_thread[c] < NT && !thr_valid[cpu_thread[c]]) cpu_thread[c] = NO_SLOT;
      if (!any) begin
         for (int c = 0; c < NC; c++) cpu_thread[c] = NO_SLOT;
         e.all_done = 1'b1;
         pending_assign = {pending_assign, e};
         return;
      end
      // Preemptive policies start from scratch; CPUs beyond the count let go.
      for (int s = 0; s < NT; s++)
         if (thr_owner[s] >= cnt || policy >= POL_SRT_P) thr_owner[s] = NO_CPU;
      for (int c = 0; c < NC; c++)
         if (c >= cnt || policy >= POL_SRT_P) cpu_thread[c] = NO_SLOT;
      for (int c = 0; c < cnt; c++) begin
         if (cpu_thread[c] == NO_SLOT) begin
            b = pick_thread(r.current_time);
            if (b != NO_SLOT) begin
               cpu_thread[c] = b;
               thr_owner[b] = c;
            end
         end
         e = '0;
         e.cpu_index = 4'(c);
         e.last = (c + 1 == cnt);
         if (cpu_thread[c] < NT) begin
            e.assigned_id = thr_id[cpu_thread[c]];
            e.cpu_busy = 1'b1;
         end
         pending_assign = {pending_assign, e};
      end
      for (int c = 0; c < cnt; c++)
         if (cpu_thread[c] < NT && thr_remaining[cpu_thread[c]] > 0)
            thr_remaining[cpu_thread[c]]--;
   endfunction

   // Offer one item; valid stays high afterward until the next call or a drain.
   task automatic send_item(input req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_dispatch(r);
   endtask

   task automatic send_create(input bit [15:0] arr, input bit [15:0] run,
                              input bit [7:0] prio, input bit [15:0] id);
      req_type r;
      r = '0;
      r.operation = OP_CREATE;
      r.arrive_at = arr;
      r.run_time = run;
      r.prio_level = prio;
      r.new_thread_id = id;
      r.current_time = 16'($urandom);
      send_item(r);
   endtask

   task automatic send_tick(input bit [15:0] now);
      req_type r;
      r = '0;
      r.operation = OP_TICK;
      r.arrive_at = 16'($urandom);
      r.run_time = 16'($urandom);
      r.prio_level = 8'($urandom);
      r.new_thread_id = 16'($urandom);
      r.current_time = now;
      send_item(r);
   endtask

   // Stop offering items and let every outstanding result come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_assign.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [1:0] pol, input logic [4:0] cpus);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_data <= {3'b0, pol};
      @(posedge clock);
      policy = pol;
      csr_index <= CSR_CPUS;
      csr_data <= cpus;
      @(posedge clock);
      cpu_count = cpus;
      csr_write <= 1'b0;
   endtask

   // Tick with the current CPU count until the table is empty.
   task automatic empty_table();
      while (!table_empty()) begin
         now_time++;
         send_tick(now_time);
      end
   endtask

   task automatic test_directed();
      send_tick(16'h0000);
      send_create(16'h0000, 16'h0000, 8'h00, 16'h0000);
      send_create(16'hFFFF, 16'h0002, 8'hFF, 16'hFFFF);
      send_create(16'h0000, 16'h0003, 8'h80, 16'h1234);
      send_create(16'h0000, 16'h0001, 8'h7F, 16'h8001);
      send_tick(16'h0000);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
      send_tick(16'h0000);
      for (int p = 0; p < 4; p++) begin
         write_config(p[1:0], 5'd2);
         send_create(16'h0001, 16'h0003, 8'h02, 16'(16'h00A0 + p));
         send_create(16'h0000, 16'h0002, 8'h05, 16'(16'h00B0 + p));
         send_create(16'h0000, 16'h0002, 8'h01, 16'(16'h00C0 + p));
         for (int t = 0; t < 4; t++) send_tick(16'(t));
      end
   endtask

   task automatic test_table_full();
      write_config(POL_SRT_P, 5'd16);
      for (int i = 0; i < NT + 3; i++)
         send_create(16'($urandom_range(0, 3)), 16'($urandom_range(1, 3)), 8'($urandom),
                     16'($urandom));
      now_time = 3;
      empty_table();
      send_tick(now_time);
   endtask

   task automatic test_cpu_count_edges();
      write_config(POL_FCFS, 5'd0);
      send_create(16'h0000, 16'h0004, 8'h10, 16'h0101);
      send_create(16'h0000, 16'h0002, 8'h10, 16'h0102);
      send_tick(16'h0001);
      write_config(POL_FCFS, 5'd31);
      send_tick(16'h0002);
      write_config(POL_SRT_NP, 5'd17);
      send_create(16'h0000, 16'h0001, 8'h10, 16'h0103);
      send_tick(16'h0003);
      write_config(POL_SRT_NP, 5'd1);
      empty_table();
   endtask

   // Mostly well-formed workloads: threads arriving near the present tick.
   task automatic test_random_phase(input logic [1:0] pol, input logic [4:0] cpus,
                                    input int n);
      write_config(pol, cpus);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 5) begin
            send_create(($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                     : 16'(now_time + $urandom_range(0, 4)),
                        ($urandom_range(0, 29) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 6)),
                        8'($urandom), 16'($urandom));
         end else if ($urandom_range(0, 14) == 0) begin
            send_tick(16'($urandom));
         end else begin
            now_time++;
            send_tick(now_time);
         end
      end
   endtask

   initial begin
      logic [4:0] mid_cpus;
      for (int s = 0; s < NT; s++) begin
         thr_valid[s] = 1'b0;
         thr_owner[s] = NO_CPU;
      end
      for (int c = 0; c < NC; c++) cpu_thread[c] = NO_SLOT;
      insert_count = 0;
      policy = POL_FCFS;
      cpu_count = 5'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_cpu_count_edges();
      mid_cpus = 5'($urandom_range(2, 15));
      test_random_phase(POL_FCFS, 5'd1, 40);
      test_random_phase(POL_SRT_NP, mid_cpus, 40);
      test_random_phase(POL_SRT_P, 5'd16, 40);
      test_random_phase(POL_PRIO_P, 5'd3, 40);
      test_random_phase(POL_FCFS, 5'd16, 40);
      test_random_phase(POL_PRIO_P, 5'd0, 40);
      idle_on = 1'b0;
      test_random_phase(POL_SRT_NP, 5'd4, 40);
      drain_results();

      $display("covered %0d creates (%0d refused as full) and %0d ticks", create_count,
               full_count, tick_count);
      $display("all four policies, CPU counts in and out of range, %0d results compared",
               checked_count);
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
